// File: rtl/core/lbss_pkg.sv
// Package with shared types and constants of the LED blink slot scheduler.
`default_nettype none

package lbss_pkg;

  localparam int unsigned LedW    = 8;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned ColourW = 3 * LevelW;
  localparam int unsigned TickW   = 16;

  // Writes emitted per tick at most, and the width of a counter of them.
  localparam int unsigned MaxResults = 8;
  localparam int unsigned EmitCntW   = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActStart = 2'd1,
    ActClear = 2'd2,
    ActNone  = 2'd3
  } action_e;

  // One slot as it lives in the slot memory; the active flag lives in flops.
  typedef struct packed {
    logic               on_phase;
    logic [LedW-1:0]    led;
    logic [ColourW-1:0] colour;
    logic [TickW-1:0]   blinks_left;
    logic [TickW-1:0]   on_limit;
    logic [TickW-1:0]   off_limit;
    logic [TickW-1:0]   tick_count;
  } slot_entry_t;

  localparam int unsigned EntryW = $bits(slot_entry_t);

endpackage

`default_nettype wire

// File: rtl/core/lbss_if.sv
// Request and result channel interfaces of the LED blink slot scheduler.
`default_nettype none

interface lbss_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [lbss_pkg::LedW-1:0]         led_index;
  logic [lbss_pkg::LevelW-1:0]       red;
  logic [lbss_pkg::LevelW-1:0]       green;
  logic [lbss_pkg::LevelW-1:0]       blue;
  logic [lbss_pkg::TickW-1:0]        blink_count;
  logic [lbss_pkg::TickW-1:0]        on_ticks;
  logic [lbss_pkg::TickW-1:0]        off_ticks;

  modport source (
    output valid, action, led_index, red, green, blue, blink_count, on_ticks, off_ticks,
    input  ready
  );
  modport sink (
    input  valid, action, led_index, red, green, blue, blink_count, on_ticks, off_ticks,
    output ready
  );
endinterface

interface lbss_res_if;
  logic                        valid;
  logic                        ready;
  logic [lbss_pkg::LedW-1:0]   out_led;
  logic [lbss_pkg::LevelW-1:0] out_red;
  logic [lbss_pkg::LevelW-1:0] out_green;
  logic [lbss_pkg::LevelW-1:0] out_blue;
  logic                        last;

  modport source (
    output valid, out_led, out_red, out_green, out_blue, last,
    input  ready
  );
  modport sink (
    input  valid, out_led, out_red, out_green, out_blue, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/lbss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lbss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/led_blink_slot_scheduler.sv
// Top level of the LED blink slot scheduler: slot memory and tick sequencer.
//
// Usage: requests arrive on req_i (valid/ready). Action tick walks all slots,
// start stores a blink task in the lowest free slot, clear empties all slots.
// Colour writes leave on res_o (valid/ready), one per slot active at the
// start of a tick, at most MaxResults per tick, the final one with last set.
// Start and clear give no result; a start with every slot busy is dropped.
// A tick visits the slots one at a time; each active slot is read from the
// slot memory while scanning (registered read), then updated and written
// back before the scan moves on to the next slot.
// Results pass through an output register, so a request may be accepted while
// the last result still waits. When the receiver stalls, the sequencer holds
// at the slot whose result is pending until the register frees up.
// Reset clears the active flags, which marks every slot empty; the slot
// memory itself needs no clearing since start rewrites a whole entry, so no
// clearing pass runs and the block is ready right after reset.
`default_nettype none

module led_blink_slot_scheduler #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lbss_req_if.sink   req_i,
  lbss_res_if.source res_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StProc
  } state_e;

  state_e                             state_q;
  logic [IdxW-1:0]                    idx_q;
  logic [SLOTS-1:0]                   active_q;
  logic [lbss_pkg::EmitCntW-1:0]      emit_cnt_q;

  logic                               out_valid_q;
  logic [lbss_pkg::LedW-1:0]          out_led_q;
  logic [lbss_pkg::ColourW-1:0]       out_colour_q;
  logic                               out_last_q;

  // Memory ports.
  logic                               ram_we;
  logic [IdxW-1:0]                    ram_waddr;
  lbss_pkg::slot_entry_t              ram_wdata;
  logic                               ram_re;
  lbss_pkg::slot_entry_t              ram_rdata;

  // Request side.
  logic                               req_fire;
  logic                               is_start;
  logic                               free_found;
  logic [IdxW-1:0]                    free_idx;
  lbss_pkg::slot_entry_t              new_entry;

  // Slot update.
  lbss_pkg::slot_entry_t              upd_entry;
  logic [lbss_pkg::TickW-1:0]         cnt_inc;
  logic [lbss_pkg::TickW-1:0]         limit;
  logic                               upd_active;
  logic                               emit_want;
  logic                               proceed;
  logic                               more_later;
  logic [SLOTS-1:0]                   later_mask;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign is_start    = req_fire && (lbss_pkg::action_e'(req_i.action) == lbss_pkg::ActStart);

  // Find the lowest-numbered free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!active_q[s]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(s);
      end
    end
  end

  always_comb begin
    new_entry.on_phase    = 1'b1;
    new_entry.led         = req_i.led_index;
    new_entry.colour      = {req_i.red, req_i.green, req_i.blue};
    new_entry.blinks_left = req_i.blink_count;
    new_entry.on_limit    = req_i.on_ticks;
    new_entry.off_limit   = req_i.off_ticks;
    new_entry.tick_count  = '0;
  end

  // Advance one slot's counter and phase on a tick.
  always_comb begin
    upd_entry  = ram_rdata;
    upd_active = 1'b1;
    cnt_inc    = ram_rdata.tick_count + lbss_pkg::TickW'(1);
    limit      = ram_rdata.on_phase ? ram_rdata.on_limit : ram_rdata.off_limit;
    upd_entry.tick_count = cnt_inc;
    if (cnt_inc >= limit) begin
      upd_entry.tick_count = '0;
      if (ram_rdata.on_phase) begin
        upd_entry.on_phase = 1'b0;
        if (ram_rdata.blinks_left != '0) begin
          upd_entry.blinks_left = ram_rdata.blinks_left - lbss_pkg::TickW'(1);
          if (ram_rdata.blinks_left == lbss_pkg::TickW'(1)) begin
            upd_active = 1'b0;
          end
        end
      end else begin
        upd_entry.on_phase = 1'b1;
      end
    end
  end

  // Any active slot above the current one still owes a write this tick.
  assign later_mask = (active_q >> idx_q) >> 1;
  assign more_later = (later_mask != '0);

  assign emit_want = (emit_cnt_q < lbss_pkg::EmitCntW'(lbss_pkg::MaxResults));
  assign proceed   = (state_q == StProc) &&
                     (!emit_want || !out_valid_q || res_o.ready);

  assign ram_re    = (state_q == StScan) && active_q[idx_q];
  assign ram_we    = (is_start && free_found) || proceed;
  assign ram_waddr = (state_q == StProc) ? idx_q : free_idx;
  assign ram_wdata = (state_q == StProc) ? upd_entry : new_entry;

  lbss_ram #(
    .Width (lbss_pkg::EntryW),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      active_q    <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the held result once the receiver takes it, unless a new one
      // loads in the same cycle.
      if (res_o.ready && !(proceed && emit_want)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (req_fire) begin
            unique case (lbss_pkg::action_e'(req_i.action))
              lbss_pkg::ActTick: begin
                idx_q      <= '0;
                emit_cnt_q <= '0;
                state_q    <= StScan;
              end
              lbss_pkg::ActStart: begin
                if (free_found) begin
                  active_q[free_idx] <= 1'b1;
                end
              end
              lbss_pkg::ActClear: begin
                active_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        StScan: begin
          if (active_q[idx_q]) begin
            state_q <= StProc;
          end else if (idx_q == LastIdx) begin
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        StProc: begin
          if (proceed) begin
            active_q[idx_q] <= upd_active;
            if (emit_want) begin
              out_valid_q  <= 1'b1;
              out_led_q    <= ram_rdata.led;
              out_colour_q <= (upd_active && upd_entry.on_phase) ? ram_rdata.colour : '0;
              out_last_q   <= !more_later ||
                              (emit_cnt_q ==
                               lbss_pkg::EmitCntW'(lbss_pkg::MaxResults - 1));
              emit_cnt_q   <= emit_cnt_q + lbss_pkg::EmitCntW'(1);
            end
            if (idx_q == LastIdx) begin
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= StScan;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_led   = out_led_q;
  assign res_o.out_red   = out_colour_q[2*lbss_pkg::LevelW +: lbss_pkg::LevelW];
  assign res_o.out_green = out_colour_q[lbss_pkg::LevelW +: lbss_pkg::LevelW];
  assign res_o.out_blue  = out_colour_q[0 +: lbss_pkg::LevelW];
  assign res_o.last      = out_last_q;

endmodule

`default_nettype wire
